FILE: sv/lbsb_pkg.sv
// shared widths, codes and helper functions for the log-spaced spectrum bar binner
// no dependencies; used by the interfaces, the top level and the checker
package lbsb_pkg;

  localparam int MAG_W   = 16;
  localparam int POS_W   = 12;
  localparam int IDX_W   = 6;
  localparam int SUM_W   = 22;
  localparam int CODE_W  = 3;
  localparam int EDGE_W  = 11;
  localparam int EDGES   = 64;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = SUM_W;

  localparam logic [CODE_W-1:0] FFT_256  = 3'd0;
  localparam logic [CODE_W-1:0] FFT_512  = 3'd1;
  localparam logic [CODE_W-1:0] FFT_1024 = 3'd2;
  localparam logic [CODE_W-1:0] FFT_2048 = 3'd3;
  localparam logic [CODE_W-1:0] FFT_4096 = 3'd4;

  localparam logic REG_FFT_SIZE = 1'b0;

  // exact test n^d <= 2^t
  function automatic logic pow_le_pow2(int n, int d, int t);
    logic [703:0] p;
    logic [703:0] lim;
    p   = 704'd1;
    lim = 704'd1 << t;
    for (int k = 0; k < d; k++) begin
      p = p * 704'(n);
    end
    return p <= lim;
  endfunction

  // edge i = largest n with n^(bars-1) <= 2^(10*i); unused entries 1024
  function automatic logic [EDGES*EDGE_W-1:0] build_edges(int bars);
    logic [EDGES*EDGE_W-1:0] tab;
    int lo;
    int hi;
    int mid;
    tab = '0;
    for (int i = 0; i < EDGES; i++) begin
      lo = 1;
      hi = 1024;
      if (i < bars) begin
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (pow_le_pow2(mid, bars - 1, 10 * i)) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
      end else begin
        lo = 1024;
      end
      tab[i*EDGE_W +: EDGE_W] = EDGE_W'(lo);
    end
    return tab;
  endfunction

  // end bin of a band: edge capped at usable bins - 1, at least start + 1
  function automatic logic [POS_W-1:0] band_end_for(logic [EDGE_W-1:0] edge_val,
                                                    logic [CODE_W-1:0] code,
                                                    logic [POS_W-1:0] start);
    logic [POS_W-1:0] cap;
    logic [POS_W-1:0] e;
    case (code)
      FFT_256:  cap = 12'd255;
      FFT_1024: cap = 12'd1023;
      FFT_2048: cap = 12'd2047;
      FFT_4096: cap = 12'd4095;
      default:  cap = 12'd511;
    endcase
    e = {1'b0, edge_val};
    if (e > cap) begin
      e = cap;
    end
    if (e <= start) begin
      e = start + 12'd1;
    end
    return e;
  endfunction

endpackage

FILE: sv/lbsb_if.sv
// valid/ready channel interfaces for magnitude bins in and bar results out
// depends on lbsb_pkg for field widths
interface lbsb_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbsb_pkg::MAG_W-1:0]   magnitude;
  logic                         frame_start;

  modport source (output valid, magnitude, frame_start, input ready);
  modport sink   (input valid, magnitude, frame_start, output ready);
endinterface

interface lbsb_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbsb_pkg::IDX_W-1:0]   bar_index;
  logic [lbsb_pkg::MAG_W-1:0]   bar_level;
  logic [lbsb_pkg::MAG_W-1:0]   energy;
  logic                         last;

  modport source (output valid, bar_index, bar_level, energy, last, input ready);
  modport sink   (input valid, bar_index, bar_level, energy, last, output ready);
endinterface

FILE: sv/log_bin_spectrum_bars.sv
// log-spaced spectrum bar binner: band peak hold, serial square root, serial mean
// depends on lbsb_pkg and the channel interfaces in lbsb_if.sv
//
// usage: bins of one frame enter on in_i in order, frame_start marking bin 0.
// bins are grouped into BARS bands whose end edges grow as 2^(10*i/(BARS-1)),
// capped by the fft size register (APB, byte address 0) and at least one bin
// wide. when a band closes, one request leaves on out_o with the bar index and
// the square root of the band peak; the last bar also carries the mean level
// in energy and sets last. bins past the last band give nothing until the next
// frame_start; a frame_start mid-frame drops the partial frame.
// timing: an item that does not close a band is taken and the block stays ready for the next item. an item that
// closes a band runs through the bit-pair-serial square root and then the emit
// state; on the last bar a bit-serial mean divider runs between them. one item is
// worked on at a time; the output register lets the next item be taken while
// a result still waits, and a stalled receiver holds the block only when the
// next result is ready to be loaded. reset sets the size code to 512 bins and
// restarts the frame state; no result is pending after reset.
module log_bin_spectrum_bars #(
  parameter int BARS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lbsb_in_if.sink                       in_i,
  lbsb_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbsb_pkg::PADDR_W-1:0]  paddr,
  input  logic [lbsb_pkg::PDATA_W-1:0]  pwdata,
  output logic [lbsb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int MW = lbsb_pkg::MAG_W;
  localparam int PW = lbsb_pkg::POS_W;
  localparam int IW = lbsb_pkg::IDX_W;
  localparam int SW = lbsb_pkg::SUM_W;
  localparam int CW = lbsb_pkg::CODE_W;
  localparam int EW = lbsb_pkg::EDGE_W;

  localparam logic [lbsb_pkg::EDGES*EW-1:0] EdgeTab = lbsb_pkg::build_edges(BARS);
  localparam logic [EW-1:0]  Edge0    = EdgeTab[EW-1:0];
  localparam logic [IW:0]    LastBar  = (IW+1)'(BARS - 1);
  localparam logic [IW:0]    BarsW    = (IW+1)'(BARS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]    state_q;
  logic [CW-1:0] code_q;
  logic [IW-1:0] bar_q;
  logic [PW-1:0] pos_q;
  logic [PW-1:0] end_q;
  logic [MW-1:0] peak_q;
  logic [SW-1:0] sum_q;
  logic          done_q;
  logic [4:0]    cnt_q;

  logic [2*MW-1:0] rad_q;
  logic [MW:0]     rem_q;
  logic [MW-1:0]   root_q;
  logic [MW-1:0]   level_q;
  logic [SW-1:0]   dvd_q;
  logic [IW-1:0]   drem_q;

  logic          out_vld_q;
  logic [IW-1:0] out_idx_q;
  logic [MW-1:0] out_lvl_q;
  logic [MW-1:0] out_nrg_q;
  logic          out_last_q;

  // config port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lbsb_pkg::REG_FFT_SIZE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lbsb_pkg::REG_FFT_SIZE) ? {{(lbsb_pkg::PDATA_W-CW){1'b0}}, code_q}
                                                      : '0;

  // item accept path
  logic          in_acc;
  logic          restart;
  logic [PW-1:0] pos_eff;
  logic [PW-1:0] end_eff;
  logic [MW-1:0] peak_eff;
  logic [MW-1:0] peak_new;
  logic [PW-1:0] pos_new;
  logic          done_eff;
  logic          close;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign restart    = in_i.frame_start;
  assign pos_eff    = restart ? '0 : pos_q;
  assign peak_eff   = restart ? '0 : peak_q;
  assign done_eff   = restart ? 1'b0 : done_q;
  assign end_eff    = restart ? lbsb_pkg::band_end_for(Edge0, code_q, '0) : end_q;
  assign peak_new   = (in_i.magnitude > peak_eff) ? in_i.magnitude : peak_eff;
  assign pos_new    = pos_eff + 12'd1;
  assign close      = !done_eff && (pos_new == end_eff);

  // square root step: two radicand bits per cycle
  logic [MW+2:0] sq_t;
  logic [MW+2:0] sq_sub;
  logic          sq_ge;
  logic [MW-1:0] root_nxt;
  assign sq_t     = {rem_q, rad_q[2*MW-1 -: 2]};
  assign sq_sub   = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_sub;
  assign root_nxt = {root_q[MW-2:0], sq_ge};

  // divide step: one quotient bit per cycle
  logic [IW:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {drem_q, dvd_q[SW-1]};
  assign dv_ge = dv_t >= BarsW;

  logic          is_last;
  logic [SW-1:0] sum_nxt;
  logic [IW-1:0] bar_nxt;
  logic [PW-1:0] end_nxt;
  assign is_last = ({1'b0, bar_q} == LastBar);
  assign sum_nxt = sum_q + {{(SW-MW){1'b0}}, root_nxt};
  assign bar_nxt = bar_q + 6'd1;
  assign end_nxt = lbsb_pkg::band_end_for(EdgeTab[bar_nxt*EW +: EW], code_q, pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      code_q    <= lbsb_pkg::FFT_512;
      bar_q     <= '0;
      pos_q     <= '0;
      end_q     <= {1'b0, Edge0};
      peak_q    <= '0;
      sum_q     <= '0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        code_q <= pwdata[CW-1:0];
      end
      if (out_vld_q && out_o.ready && (state_q != ST_EMIT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (restart) begin
              bar_q <= '0;
              sum_q <= '0;
            end
            done_q <= done_eff;
            end_q  <= end_eff;
            if (done_eff) begin
              pos_q  <= pos_eff;
              peak_q <= peak_eff;
            end else begin
              pos_q  <= pos_new;
              peak_q <= close ? '0 : peak_new;
            end
            if (close) begin
              cnt_q   <= '0;
              state_q <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (cnt_q == 5'(lbsb_pkg::SQRT_STEPS - 1)) begin
            sum_q <= sum_nxt;
            cnt_q <= '0;
            state_q <= is_last ? ST_DIV : ST_EMIT;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(lbsb_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q <= 1'b1;
            if (is_last) begin
              done_q <= 1'b1;
            end else begin
              bar_q <= bar_nxt;
              end_q <= end_nxt;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && close) begin
          rad_q  <= {peak_new, {MW{1'b0}}};
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        rad_q  <= {rad_q[2*MW-3:0], 2'b00};
        rem_q  <= sq_ge ? (MW+1)'(sq_t - sq_sub) : sq_t[MW:0];
        root_q <= root_nxt;
        if (cnt_q == 5'(lbsb_pkg::SQRT_STEPS - 1)) begin
          level_q <= root_nxt;
          dvd_q   <= sum_nxt;
          drem_q  <= '0;
        end
      end
      ST_DIV: begin
        drem_q <= dv_ge ? IW'(dv_t - BarsW) : dv_t[IW-1:0];
        dvd_q  <= {dvd_q[SW-2:0], dv_ge};
      end
      ST_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_idx_q  <= bar_q;
          out_lvl_q  <= level_q;
          out_nrg_q  <= is_last ? dvd_q[MW-1:0] : '0;
          out_last_q <= is_last;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.bar_index = out_idx_q;
  assign out_o.bar_level = out_lvl_q;
  assign out_o.energy    = out_nrg_q;
  assign out_o.last      = out_last_q;

endmodule

FILE: sv/lbsb_checker.sv
// port-level checks for log_bin_spectrum_bars, attached by bind
// depends on lbsb_pkg and the top level's ports
module lbsb_checker #(
  parameter int BARS = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lbsb_pkg::IDX_W-1:0]   out_bar_index,
  input logic [lbsb_pkg::MAG_W-1:0]   out_energy,
  input logic                         out_last
);

  localparam logic [lbsb_pkg::IDX_W:0] LastBar = (lbsb_pkg::IDX_W+1)'(BARS - 1);

  // a stalled request stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  // energy only rides on the final bar
  a_energy_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> out_energy == '0)
    else $error("energy set on a bar that is not last");

  // final bar carries the top index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_last |-> {1'b0, out_bar_index} == LastBar)
    else $error("last flag on wrong bar index");

  // indices stay within the bar count
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> {1'b0, out_bar_index} <= LastBar)
    else $error("bar index beyond bar count");

endmodule

bind log_bin_spectrum_bars lbsb_checker #(.BARS(BARS)) u_lbsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_bar_index (out_o.bar_index),
  .out_energy    (out_o.energy),
  .out_last      (out_o.last)
);

FILE: tb/sv/tb_top.sv
// self-checking bench for log_bin_spectrum_bars: streams magnitude bins, predicts bars
// depends on lbsb_pkg, lbsb_in_if / lbsb_out_if and the log_bin_spectrum_bars top level
// checks every bar request field by field across fft size settings and idle patterns
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAG_W   = lbsb_pkg::MAG_W;
  localparam int IDX_W   = lbsb_pkg::IDX_W;
  localparam int POS_W   = lbsb_pkg::POS_W;
  localparam int SUM_W   = lbsb_pkg::SUM_W;
  localparam int CODE_W  = lbsb_pkg::CODE_W;
  localparam int PADDR_W = lbsb_pkg::PADDR_W;
  localparam int PDATA_W = lbsb_pkg::PDATA_W;

  localparam int BARS         = 32;
  localparam int LIMIT        = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_BINS  = 1500;
  localparam int BIG_W        = 720;

  localparam logic [CODE_W-1:0] CODE_SPARE_LO  = 3'd5;
  localparam logic [CODE_W-1:0] CODE_SPARE_MID = 3'd6;
  localparam logic [CODE_W-1:0] CODE_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_start;
  } bin_t;

  typedef struct packed {
    logic [IDX_W-1:0] bar_index;
    logic [MAG_W-1:0] bar_level;
    logic [MAG_W-1:0] energy;
    logic             last;
  } bar_t;

  localparam bin_t DIRECTED_BINS [20] = '{
    '{16'hFFFF, 1'b0}, '{16'h0000, 1'b0}, '{16'h0001, 1'b0}, '{16'h8000, 1'b0},
    '{16'h7FFF, 1'b0}, '{16'hFFFF, 1'b1}, '{16'h5555, 1'b0}, '{16'hAAAA, 1'b0},
    '{16'h0100, 1'b0}, '{16'h0010, 1'b0}, '{16'hFFFE, 1'b0}, '{16'h0002, 1'b0},
    '{16'h0000, 1'b1}, '{16'h0000, 1'b0}, '{16'h00FF, 1'b0}, '{16'hFF00, 1'b0},
    '{16'h1234, 1'b0}, '{16'h0004, 1'b0}, '{16'hC000, 1'b0}, '{16'h3FFF, 1'b0}
  };

  localparam logic [CODE_W-1:0] PHASE_CODES [9] = '{
    lbsb_pkg::FFT_256, lbsb_pkg::FFT_4096, CODE_SPARE_HI, lbsb_pkg::FFT_1024,
    CODE_SPARE_LO, lbsb_pkg::FFT_2048, lbsb_pkg::FFT_512, CODE_SPARE_MID,
    lbsb_pkg::FFT_256
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  lbsb_in_if  bins_if ();
  lbsb_out_if bars_if ();

  log_bin_spectrum_bars #(.BARS(BARS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (bins_if),
    .out_o   (bars_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bin_t pending_bins [$];
  bar_t bars_due [$];
  bin_t on_bus;

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int bins_taken;
  int bars_seen;
  int cycle_count;

  // predictor state
  int               edge_tab [BARS];
  logic [CODE_W-1:0] size_code;
  logic [IDX_W-1:0] bar_num;
  logic [POS_W-1:0] bin_pos;
  logic [POS_W-1:0] band_stop;
  logic [MAG_W-1:0] peak_hold;
  logic [SUM_W-1:0] level_acc;
  logic             frame_over;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int usable_bins(logic [CODE_W-1:0] code);
    case (code)
      lbsb_pkg::FFT_256:  return 256;
      lbsb_pkg::FFT_1024: return 1024;
      lbsb_pkg::FFT_2048: return 2048;
      lbsb_pkg::FFT_4096: return 4096;
      default:            return 512;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] close_edge(int bar, int start);
    int e;
    int cap;
    e   = edge_tab[bar];
    cap = usable_bins(size_code) - 1;
    if (e > cap) begin
      e = cap;
    end
    if (e <= start) begin
      e = start + 1;
    end
    return POS_W'(e);
  endfunction

  function automatic logic [MAG_W-1:0] root_of_peak(logic [MAG_W-1:0] pk);
    logic [31:0]      v;
    logic [MAG_W-1:0] r;
    logic [MAG_W-1:0] t;
    v = {pk, 16'h0000};
    r = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      t = r | (MAG_W'(1) << b);
      if (32'(t) * 32'(t) <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  function automatic void restart_bands();
    bar_num    = '0;
    bin_pos    = '0;
    peak_hold  = '0;
    level_acc  = '0;
    frame_over = 1'b0;
    band_stop  = close_edge(0, 0);
  endfunction

  function automatic void bin_into_bands(bin_t b);
    bar_t             r;
    logic [MAG_W-1:0] level;
    logic             at_end;
    if (b.frame_start) begin
      restart_bands();
    end
    if (frame_over) begin
      return;
    end
    if (b.magnitude > peak_hold) begin
      peak_hold = b.magnitude;
    end
    bin_pos = bin_pos + 1'b1;
    if (bin_pos != band_stop) begin
      return;
    end
    level     = root_of_peak(peak_hold);
    level_acc = level_acc + SUM_W'(level);
    at_end    = (int'(bar_num) + 1 >= BARS);
    r.bar_index = bar_num;
    r.bar_level = level;
    r.energy    = at_end ? MAG_W'(level_acc / BARS) : '0;
    r.last      = at_end;
    bars_due.push_back(r);
    peak_hold = '0;
    if (at_end) begin
      frame_over = 1'b1;
    end else begin
      bar_num   = bar_num + 1'b1;
      band_stop = close_edge(int'(bar_num), int'(bin_pos));
    end
  endfunction

  // driver: request held until taken, predictor fed on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bins_if.valid && bins_if.ready) begin
        bin_into_bands(on_bus);
        bins_taken++;
      end
      if (!bins_if.valid || bins_if.ready) begin
        if (pending_bins.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_bins.pop_front();
          bins_if.valid       <= 1'b1;
          bins_if.magnitude   <= on_bus.magnitude;
          bins_if.frame_start <= on_bus.frame_start;
        end else begin
          bins_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each bar request with the oldest prediction
  always @(posedge clk_i) begin : watch_bars
    bar_t got;
    bar_t want;
    if (rst_ni) begin
      if (bars_if.valid && bars_if.ready) begin
        got.bar_index = bars_if.bar_index;
        got.bar_level = bars_if.bar_level;
        got.energy    = bars_if.energy;
        got.last      = bars_if.last;
        bars_seen++;
        if (bars_due.size() == 0) begin
          $display("%0t unexpected bar: index %0d level %h energy %h last %b", $time,
                   got.bar_index, got.bar_level, got.energy, got.last);
          errors++;
        end else begin
          want = bars_due.pop_front();
          if (got !== want) begin
            $display("%0t bar mismatch: expected index %0d level %h energy %h last %b, %s",
                     $time, want.bar_index, want.bar_level, want.energy, want.last,
                     $sformatf("got index %0d level %h energy %h last %b",
                               got.bar_index, got.bar_level, got.energy, got.last));
            errors++;
          end
        end
      end
      bars_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d bars still due", cycle_count, bars_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {lbsb_pkg::REG_FFT_SIZE, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_fft_size(input logic [CODE_W-1:0] code);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, PDATA_W'(code), rd);
    size_code = code;
    apb_access(1'b0, '0, rd);
    if (rd[CODE_W-1:0] !== code) begin
      $display("%0t fft size readback: expected %0d, got %0d", $time, code, rd[CODE_W-1:0]);
      errors++;
    end
  endtask

  // sampled away from the rising edge so driver and monitor updates have landed
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (pending_bins.size() != 0 || bins_if.valid || bars_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int               lo;
    int               hi;
    int               mid;
    logic [BIG_W-1:0] pw;
    logic [CODE_W-1:0] code;
    int               n_items;
    int               phase;
    int               len;
    int               span;
    logic             trunc;
    logic             trunc_prev;
    logic             cont;
    bin_t             b;

    rst_ni              = 1'b0;
    bins_if.valid       = 1'b0;
    bins_if.magnitude   = '0;
    bins_if.frame_start = 1'b0;
    bars_if.ready       = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    errors              = 0;
    bins_taken          = 0;
    bars_seen           = 0;
    cycle_count         = 0;
    n_items             = 0;
    trunc_prev          = 1'b0;

    // band edges: largest n with n^(BARS-1) <= 2^(10*i)
    for (int i = 0; i < BARS; i++) begin
      lo = 1;
      hi = 1024;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        pw  = BIG_W'(1);
        for (int k = 0; k < BARS - 1; k++) begin
          pw = pw * BIG_W'(mid);
        end
        if (pw <= (BIG_W'(1) << (10 * i))) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      edge_tab[i] = lo;
    end
    size_code = lbsb_pkg::FFT_512;
    restart_bands();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset size, no leading frame start, extremes, restart mid-frame
    foreach (DIRECTED_BINS[i]) begin
      pending_bins.push_back(DIRECTED_BINS[i]);
    end
    settle();

    for (phase = 0; phase < $size(PHASE_CODES) || n_items < RANDOM_BINS; phase++) begin
      code = PHASE_CODES[phase % $size(PHASE_CODES)];
      set_fft_size(code);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      span = usable_bins(code);
      if (span == 256) begin
        trunc = ($urandom_range(5) == 0);
        len   = trunc ? $urandom_range(255, 1) : span + $urandom_range(20, 6);
      end else if (span == 512) begin
        trunc = ($urandom_range(2) != 0);
        len   = trunc ? $urandom_range(300, 1) : span + $urandom_range(20, 6);
      end else begin
        trunc = 1'b1;
        len   = $urandom_range(200, 1);
      end
      // a cut-off frame may carry on under the new size
      cont = trunc_prev && ($urandom_range(1) == 1);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(9))
          0: b.magnitude = '0;
          1: b.magnitude = '1;
          2: b.magnitude = MAG_W'($urandom_range(255));
          default: b.magnitude = MAG_W'($urandom_range(16'hFFFF));
        endcase
        b.frame_start = (j == 0 && !cont) || ($urandom_range(299) == 0);
        pending_bins.push_back(b);
        n_items++;
      end
      settle();
      trunc_prev = trunc;
    end

    $display("covered %0d bins in %0d size phases, all size codes and idle patterns",
             bins_taken, phase);
    $display("checked %0d bar requests, %0d mismatches", bars_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/lbsb_pkg.sv
sv/lbsb_if.sv
sv/log_bin_spectrum_bars.sv
sv/lbsb_checker.sv
tb/sv/tb_top.sv
